FILE: hdl/grill_telemetry_packet_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Grill telemetry packet decoder: assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRILL_TELEMETRY_PACKET_DECODER_UNIT_DEFINES_SVH
`define GRILL_TELEMETRY_PACKET_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold in the same cycle as the trigger
`define GTPD_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);
// Condition that must hold in the cycle after the trigger
`define GTPD_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);
`else
`define GTPD_ASSERT_SAME(label, clk, rst, trig, cond, msg)
`define GTPD_ASSERT_NEXT(label, clk, rst, trig, cond, msg)
`endif

`endif

FILE: hdl/gtpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grill telemetry packet decoder package
// Payload types, offsets, result codes and the emitter state type.
// ----------------------------------------------------------------------------
package gtpd_pkg;

  // Byte offsets within a packet
  localparam logic [5:0] OFF_FIRST    = 6'd6;
  localparam logic [5:0] OFF_GRAMS_LO = 6'd23;
  localparam logic [5:0] OFF_PERCENT  = 6'd31;
  localparam logic [5:0] MIN_LEN      = 6'd24;
  localparam logic [5:0] POS_MAX      = 6'd32;

  // Capture bank layout (index = offset - OFF_FIRST)
  localparam int CAP_BYTES   = 18;
  localparam int CAP_BURNER  = 0;
  localparam int CAP_CORE    = 8;
  localparam int CAP_GRAMS_HI = 16;
  localparam int CAP_GRAMS_LO = 17;

  localparam logic [7:0] PERCENT_MAX = 8'd100;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_ABSENT_MARKER = 2'd0;
  localparam logic [1:0] CFG_BURNER_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_PROBE_LIMIT   = 2'd2;

  localparam logic [11:0] ABSENT_MARKER_RST = 12'd1500;
  localparam logic [11:0] BURNER_LIMIT_RST  = 12'd500;
  localparam logic [11:0] PROBE_LIMIT_RST   = 12'd150;

  // Result groups
  localparam logic [1:0] GRP_BURNER = 2'd0;
  localparam logic [1:0] GRP_PROBE  = 2'd1;
  localparam logic [1:0] GRP_GAS    = 2'd2;

  // Result actions
  localparam logic [1:0] ACT_STORE   = 2'd0;
  localparam logic [1:0] ACT_ABSENT  = 2'd1;
  localparam logic [1:0] ACT_DISCARD = 2'd2;
  localparam logic [1:0] ACT_SHORT   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  group;
    logic [1:0]  zone;
    logic [1:0]  action;
    logic [11:0] reading;
    logic        final_result;
  } out_item_t;

  typedef enum logic [2:0] {
    EMIT_IDLE,
    EMIT_BURNER,
    EMIT_PROBE,
    EMIT_GAS,
    EMIT_DROP
  } emit_state_t;

  // x / 10 for an 8-bit value through the reciprocal 205 / 2048
  function automatic logic [4:0] div10_u8(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd205;
    return prod[15:11];
  endfunction

endpackage

FILE: hdl/grill_telemetry_packet_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grill telemetry packet decoder
// Byte-wise packet capture with a result emitter for burner, probe and gas.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one packet byte per transaction, last_byte set on the final byte.
//   out_* : result transactions; final_result marks the last one of a packet.
//   cfg_* : register writes (0 absent marker, 1 burner limit, 2 probe limit);
//           cfg_ready is always high, index 3 is ignored.
// Throughput: one byte per cycle. Bytes without last_byte are always taken.
//   A last byte is taken once the emitter is idle or hands over its final
//   result in that cycle, since its captured fields go into the snapshot bank.
// Results: the first result of a packet passes the emitter state register
//   and then the output register. A short packet gives one result; a full
//   packet gives 2*ZONES + 1, one per cycle while out_ready stays high.
// Stall: results sit in the output register while out_ready is low; the
//   emitter waits, bytes keep flowing into the capture bank.
// Reset: clears the byte position, the emitter and the output valid, and
//   loads the register reset values. Capture data is not cleared.
// ----------------------------------------------------------------------------
`include "grill_telemetry_packet_decoder_unit_defines.svh"

module grill_telemetry_packet_decoder_unit
  import gtpd_pkg::*;
#(
  parameter int ZONES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int NPAIR = 2 * ZONES;

  // Configuration registers
  logic [11:0] absent_marker;
  logic [11:0] burner_limit;
  logic [11:0] probe_limit;

  // Input side
  logic [5:0]  pos;
  logic [5:0]  pos_inc;
  logic [7:0]  field_q [CAP_BYTES];
  logic [7:0]  cap_view [CAP_BYTES];
  logic [7:0]  percent_q;
  logic [7:0]  pct_view;
  logic        in_accept;
  logic        cap_wr;
  logic [4:0]  cap_idx;
  logic        pct_wr;
  logic        snap_load;
  logic        pkt_short;
  logic        pkt_has_pct;
  logic        gas_ok_in;
  logic [6:0]  gas_pct_in;

  // Snapshot bank and emitter
  logic [15:0]  pair_q [NPAIR];
  logic         gas_ok;
  logic [6:0]   gas_pct;
  emit_state_t  state;
  emit_state_t  state_next;
  logic [1:0]   zone_cnt;
  logic         zone_last;
  logic         load;
  logic         emit_done;
  logic         shift_en;
  out_item_t    res;
  logic [4:0]   lo_div;
  logic [11:0]  temp;
  logic [11:0]  limit_sel;

  // Configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      absent_marker <= ABSENT_MARKER_RST;
      burner_limit  <= BURNER_LIMIT_RST;
      probe_limit   <= PROBE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ABSENT_MARKER: absent_marker <= cfg_data;
        CFG_BURNER_LIMIT:  burner_limit  <= cfg_data;
        CFG_PROBE_LIMIT:   probe_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold a last byte until the emitter can take a new snapshot
  assign emit_done = load && res.final_result;
  assign in_ready  = !in_data.last_byte || (state == EMIT_IDLE) || emit_done;
  assign in_accept = in_valid && in_ready;
  assign snap_load = in_accept && in_data.last_byte;

  // Byte position, saturating
  assign pos_inc = (pos < POS_MAX) ? pos + 6'd1 : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_accept) begin
      pos <= in_data.last_byte ? '0 : pos_inc;
    end
  end

  // Capture the field bytes and the percent byte
  assign cap_wr  = in_accept && (pos inside {[OFF_FIRST:OFF_GRAMS_LO]});
  assign cap_idx = 5'(pos - OFF_FIRST);
  assign pct_wr  = in_accept && (pos == OFF_PERCENT);

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP_BYTES; i++) begin
      if (cap_wr && cap_idx == 5'(i)) begin
        field_q[i] <= in_data.data_byte;
      end
    end
    if (pct_wr) begin
      percent_q <= in_data.data_byte;
    end
  end

  // Present the byte of this transaction together with the stored ones
  always_comb begin
    for (int i = 0; i < CAP_BYTES; i++) begin
      cap_view[i] = (cap_wr && cap_idx == 5'(i)) ? in_data.data_byte : field_q[i];
    end
  end
  assign pct_view = pct_wr ? in_data.data_byte : percent_q;

  // Packet length checks and gas decode at packet end
  assign pkt_short   = pos_inc < MIN_LEN;
  assign pkt_has_pct = pos_inc > OFF_PERCENT;
  assign gas_ok_in   = pkt_has_pct &&
                       !(pct_view == 8'd0 && cap_view[CAP_GRAMS_HI] == 8'd0 &&
                         cap_view[CAP_GRAMS_LO] == 8'd0);
  assign gas_pct_in  = (pct_view > PERCENT_MAX) ? 7'(PERCENT_MAX) : 7'(pct_view);

  // Snapshot the temperature pairs; shift one pair out per temperature result
  for (genvar j = 0; j < NPAIR; j++) begin : g_pair
    localparam int Base = (j < ZONES) ? CAP_BURNER + 2 * j : CAP_CORE + 2 * (j - ZONES);
    always_ff @(posedge clk) begin
      if (snap_load) begin
        pair_q[j] <= {cap_view[Base], cap_view[Base + 1]};
      end else if (shift_en && j < NPAIR - 1) begin
        pair_q[j] <= pair_q[(j < NPAIR - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      gas_ok  <= gas_ok_in;
      gas_pct <= gas_pct_in;
    end
  end

  // Emitter state and zone counter
  assign load      = (state != EMIT_IDLE) && (!out_valid || out_ready);
  assign zone_last = (zone_cnt == 2'(ZONES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= EMIT_IDLE;
      zone_cnt <= '0;
    end else begin
      state <= state_next;
      if (snap_load || (shift_en && zone_last)) begin
        zone_cnt <= '0;
      end else if (shift_en) begin
        zone_cnt <= zone_cnt + 2'd1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    if (load) begin
      case (state)
        EMIT_BURNER: if (zone_last) state_next = EMIT_PROBE;
        EMIT_PROBE:  if (zone_last) state_next = EMIT_GAS;
        EMIT_GAS:    state_next = EMIT_IDLE;
        EMIT_DROP:   state_next = EMIT_IDLE;
        default:     state_next = EMIT_IDLE;
      endcase
    end
    if (snap_load) begin
      state_next = pkt_short ? EMIT_DROP : EMIT_BURNER;
    end
  end

  // Decode the head pair: hi * 10 + lo / 10
  assign lo_div    = div10_u8(pair_q[0][7:0]);
  assign temp      = (12'(pair_q[0][15:8]) << 3) + (12'(pair_q[0][15:8]) << 1) + 12'(lo_div);
  assign limit_sel = (state == EMIT_PROBE) ? probe_limit : burner_limit;

  // Result of the current emitter state
  always_comb begin
    res      = '0;
    shift_en = 1'b0;
    case (state)
      EMIT_BURNER, EMIT_PROBE: begin
        shift_en  = load;
        res.group = (state == EMIT_PROBE) ? GRP_PROBE : GRP_BURNER;
        res.zone  = zone_cnt;
        if (temp >= absent_marker) begin
          res.action = ACT_ABSENT;
        end else if (temp > limit_sel) begin
          res.action  = ACT_DISCARD;
          res.reading = temp;
        end else begin
          res.action  = ACT_STORE;
          res.reading = temp;
        end
      end
      EMIT_GAS: begin
        res.group        = GRP_GAS;
        res.action       = gas_ok ? ACT_STORE : ACT_ABSENT;
        res.reading      = gas_ok ? 12'(gas_pct) : 12'd0;
        res.final_result = 1'b1;
      end
      EMIT_DROP: begin
        res.group        = GRP_BURNER;
        res.action       = ACT_SHORT;
        res.final_result = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  `GTPD_ASSERT_SAME(a_last_needs_free_emitter, clk, rst, snap_load, (state == EMIT_IDLE) || emit_done, "last byte accepted while emitter busy")
  `GTPD_ASSERT_NEXT(a_pos_clear_after_last, clk, rst, snap_load, pos == 6'd0, "byte position not cleared after packet end")
  `GTPD_ASSERT_NEXT(a_short_gives_drop, clk, rst, snap_load && pkt_short, state == EMIT_DROP, "short packet did not start a drop result")
  `GTPD_ASSERT_NEXT(a_final_ends_packet, clk, rst, emit_done && !snap_load, state == EMIT_IDLE, "emitter still busy after final result")
  `GTPD_ASSERT_SAME(a_pos_saturates, clk, rst, 1'b1, pos <= POS_MAX, "byte position beyond saturation")

endmodule

FILE: tb/sv/gtpd_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grill telemetry decoder result checker
// Tracks the byte position, capture bank and limit registers of the decoder,
// queues the results each packet should produce and compares them in order.
// ----------------------------------------------------------------------------
package gtpd_check_pkg;
  import gtpd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  class decode_checker;
    logic [11:0] absent_marker;
    logic [11:0] burner_limit;
    logic [11:0] probe_limit;
    logic [5:0]  position;
    logic [7:0]  captured [CAP_BYTES];
    logic [7:0]  percent;
    out_item_t   expected_results[$];
    int          zone_count;
    int          errors;
    int          results_checked;
    int          packets;
    int          short_packets;
    int          gas_packets;

    function new(int zones);
      zone_count    = zones;
      absent_marker = ABSENT_MARKER_RST;
      burner_limit  = BURNER_LIMIT_RST;
      probe_limit   = PROBE_LIMIT_RST;
      position      = '0;
      percent       = '0;
      foreach (captured[i]) captured[i] = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply a register write; the spare index has no effect
    function void write_register(logic [1:0] index, logic [11:0] value);
      case (index)
        CFG_ABSENT_MARKER: absent_marker = value;
        CFG_BURNER_LIMIT:  burner_limit  = value;
        CFG_PROBE_LIMIT:   probe_limit   = value;
        default: ;
      endcase
    endfunction

    // Decode one temperature pair and classify it against marker and limit
    function out_item_t temp_result(logic [1:0] grp, logic [1:0] zidx, int base,
                                    logic [11:0] limit);
      int        v;
      out_item_t r;
      v = int'(captured[base + 2 * zidx]) * 10 + int'(captured[base + 2 * zidx + 1]) / 10;
      r = '{group: grp, zone: zidx, action: ACT_STORE, reading: 12'(v),
            final_result: 1'b0};
      if (v >= absent_marker) begin
        r.action  = ACT_ABSENT;
        r.reading = '0;
      end else if (v > limit) begin
        r.action = ACT_DISCARD;
      end
      return r;
    endfunction

    // Capture one accepted byte; queue the packet's results on its last byte
    function void note_byte(in_item_t item);
      logic [15:0] grams;
      out_item_t   gas;
      if (position >= OFF_FIRST && position <= OFF_GRAMS_LO)
        captured[position - OFF_FIRST] = item.data_byte;
      else if (position == OFF_PERCENT)
        percent = item.data_byte;
      if (position < POS_MAX)
        position++;
      if (!item.last_byte)
        return;

      packets++;
      if (position < MIN_LEN) begin
        short_packets++;
        expected_results.push_back('{group: GRP_BURNER, zone: 2'd0, action: ACT_SHORT,
                                     reading: 12'd0, final_result: 1'b1});
      end else begin
        for (int z = 0; z < zone_count; z++)
          expected_results.push_back(temp_result(GRP_BURNER, 2'(z), CAP_BURNER,
                                                 burner_limit));
        for (int z = 0; z < zone_count; z++)
          expected_results.push_back(temp_result(GRP_PROBE, 2'(z), CAP_CORE,
                                                 probe_limit));
        // Gas percent needs offset 31; percent and both grams bytes zero means no reading
        grams = {captured[CAP_GRAMS_HI], captured[CAP_GRAMS_LO]};
        gas = '{group: GRP_GAS, zone: 2'd0, action: ACT_ABSENT, reading: 12'd0,
                final_result: 1'b1};
        if (position > OFF_PERCENT) begin
          gas_packets++;
          if (!(percent == 8'd0 && grams == 16'd0)) begin
            gas.action  = ACT_STORE;
            gas.reading = (percent > PERCENT_MAX) ? 12'(PERCENT_MAX) : 12'(percent);
          end
        end
        expected_results.push_back(gas);
      end
      position = '0;
    endfunction

    // Compare one accepted result against the oldest queued one
    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d arrived with none queued: group %0d zone %0d action %0d reading %0d final %0d",
                   results_checked, got.group, got.zone, got.action, got.reading,
                   got.final_result);
        return;
      end
      want = expected_results.pop_front();
      if (got.group !== want.group || got.zone !== want.zone ||
          got.action !== want.action || got.reading !== want.reading ||
          got.final_result !== want.final_result) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d differs: want group %0d zone %0d action %0d reading %0d final %0d, got group %0d zone %0d action %0d reading %0d final %0d",
                   results_checked, want.group, want.zone, want.action, want.reading,
                   want.final_result, got.group, got.zone, got.action, got.reading,
                   got.final_result);
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grill telemetry packet decoder testbench
// Streams packets of every length class through the byte channel under random
// gaps and output stalls, reprograms the three limit registers between phases
// and checks every result transaction in order against a predicted queue.
// ----------------------------------------------------------------------------
module tb;
  import gtpd_pkg::*;
  import gtpd_check_pkg::*;

  localparam int          ZONES        = 4;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_BYTES = 60;
  localparam int          PHASES       = 6;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          SETTLE       = 20;
  localparam int          LONG_LEN     = 66;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;
  localparam logic [11:0] REG_MAX      = 12'hFFF;
  localparam logic [11:0] TEMP_MAX     = 12'd2575;

  typedef logic [7:0] byte_q_t[$];

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data  = '0;

  decode_checker chk;
  int            cycle_count = 0;
  int            bytes_sent  = 0;
  int            reg_writes  = 0;
  logic          in_burst    = 1'b0;
  logic          out_burst   = 1'b0;

  grill_telemetry_packet_decoder_unit #(.ZONES(ZONES)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("grill_telemetry_packet_decoder_unit: mismatch");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  // Present one byte after a random gap and hold it until the transaction
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, last_byte: last};
    do @(posedge clk); while (!in_ready);
    chk.note_byte('{data_byte: value, last_byte: last});
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t payload);
    in_burst = ($urandom_range(0, 3) == 0);
    foreach (payload[i]) send_byte(payload[i], i == payload.size() - 1);
  endtask

  // Hold the sender until every queued result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    chk.write_register(index, value);
    reg_writes++;
  endtask

  // Reprogram all limits on an idle block, plus a write to the spare index
  task automatic load_limits(input logic [11:0] marker, input logic [11:0] burner,
                             input logic [11:0] probe);
    drain();
    write_reg(CFG_ABSENT_MARKER, marker);
    write_reg(CFG_BURNER_LIMIT, burner);
    write_reg(CFG_PROBE_LIMIT, probe);
    write_reg(CFG_UNUSED, 12'($urandom_range(0, 4095)));
    cfg_valid <= 1'b0;
  endtask

  // Pick a byte for a packet offset, steering temperatures toward thresholds
  function automatic logic [7:0] pick_byte(input int offset);
    int hi;
    int limit;
    if (offset >= OFF_FIRST && offset < OFF_FIRST + CAP_GRAMS_HI &&
        (offset - OFF_FIRST) % 2 == 0) begin
      limit = (offset < OFF_FIRST + CAP_CORE) ? chk.burner_limit : chk.probe_limit;
      case ($urandom_range(0, 3))
        0: hi = $urandom_range(0, 20);
        1: hi = $urandom_range(0, 255);
        2: hi = limit / 10 + int'($urandom_range(0, 2)) - 1;
        default: hi = int'(chk.absent_marker) / 10 + int'($urandom_range(0, 2)) - 1;
      endcase
      if (hi < 0) hi = 0;
      if (hi > 255) hi = 255;
      return 8'(hi);
    end
    if (offset == OFF_PERCENT) begin
      case ($urandom_range(0, 3))
        0: return 8'd0;
        1: return 8'(PERCENT_MAX - 1 + $urandom_range(0, 2));
        default: return 8'($urandom_range(0, 255));
      endcase
    end
    if (offset == OFF_FIRST + CAP_GRAMS_HI || offset == OFF_GRAMS_LO)
      return ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic byte_q_t random_packet(input int len);
    byte_q_t pkt;
    for (int i = 0; i < len; i++) pkt.push_back(pick_byte(i));
    return pkt;
  endfunction

  // Take results after random stalls, with stretches of no stall
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      chk.check_result(out_data);
    end
  end

  initial begin
    byte_q_t    pkt;
    logic [7:0] boundary_temps [16];
    int         start_bytes;
    int         len;
    chk = new(ZONES);
    // hi/lo pairs: 500, 501, 1500, 1499 for burners; 150, 151, 0, 2575 for probes
    boundary_temps = '{8'd50, 8'd9, 8'd50, 8'd10, 8'd150, 8'd0, 8'd149, 8'd99,
                       8'd15, 8'd0, 8'd15, 8'd10, 8'd0, 8'd0, 8'd255, 8'd255};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Short packets at both ends of the short range
    pkt = random_packet(1);
    send_packet(pkt);
    pkt = random_packet(MIN_LEN - 1);
    send_packet(pkt);

    // Minimum full packet with temperatures on both sides of each threshold
    pkt = random_packet(MIN_LEN);
    foreach (boundary_temps[i]) pkt[OFF_FIRST + i] = boundary_temps[i];
    send_packet(pkt);

    // Percent above the clamp with zero grams
    pkt = random_packet(POS_MAX);
    pkt[OFF_FIRST + CAP_GRAMS_HI] = 8'd0;
    pkt[OFF_GRAMS_LO] = 8'd0;
    pkt[OFF_PERCENT] = 8'hFF;
    send_packet(pkt);

    // Percent and grams both zero
    pkt = random_packet(POS_MAX + 1);
    pkt[OFF_FIRST + CAP_GRAMS_HI] = 8'd0;
    pkt[OFF_GRAMS_LO] = 8'd0;
    pkt[OFF_PERCENT] = 8'd0;
    send_packet(pkt);

    // Long packet past the counter width; trailing bytes must be ignored
    pkt = random_packet(LONG_LEN);
    pkt[OFF_FIRST + CAP_GRAMS_HI] = 8'd1;
    pkt[OFF_GRAMS_LO] = 8'd0;
    pkt[OFF_PERCENT] = 8'd0;
    for (int i = POS_MAX; i < LONG_LEN; i++) pkt[i] = 8'hFF;
    send_packet(pkt);
    drain();

    // Random packets across several limit settings
    start_bytes = bytes_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: load_limits(12'($urandom_range(0, TEMP_MAX)), 12'($urandom_range(0, TEMP_MAX)),
                       12'($urandom_range(0, TEMP_MAX)));
        2: load_limits('0, '0, '0);
        3: load_limits(REG_MAX, REG_MAX, REG_MAX);
        4: load_limits(TEMP_MAX, TEMP_MAX, '0);
        5: load_limits(ABSENT_MARKER_RST, 12'($urandom_range(0, TEMP_MAX)),
                       12'($urandom_range(0, 400)));
        default: ;
      endcase
      while (bytes_sent - start_bytes < (ph + 1) * RANDOM_BYTES / PHASES) begin
        if ($urandom_range(0, 7) == 0) drain();
        case ($urandom_range(0, 9))
          0, 1:    len = $urandom_range(1, MIN_LEN - 1);
          2, 3, 4: len = $urandom_range(MIN_LEN, POS_MAX - 1);
          9:       len = $urandom_range(POS_MAX, LONG_LEN);
          default: len = $urandom_range(POS_MAX, POS_MAX + 4);
        endcase
        pkt = random_packet(len);
        send_packet(pkt);
      end
    end

    // Let the last results out, then settle
    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d packets (%0d short, %0d reaching the gas percent byte), %0d bytes;",
             chk.packets, chk.short_packets, chk.gas_packets, bytes_sent);
    $display("checked %0d results with %0d errors over %0d register writes.",
             chk.results_checked, chk.errors, reg_writes);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("grill_telemetry_packet_decoder_unit: match");
    end else begin
      $display("grill_telemetry_packet_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
